>>> design/button_gesture_router_defines.svh
// ----------------------------------------------------------------------------
// Button gesture router assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_ROUTER_DEFINES_SVH
`define BUTTON_GESTURE_ROUTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bgr_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture router package
// Types, codes and constants shared by the router modules.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam logic [7:0] MOUSE_ONE_CODE = 8'd200;
  localparam logic [7:0] MOUSE_TWO_CODE = 8'd201;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ENABLE      = 3'd0,
    CFG_TOGGLE_BTN  = 3'd1,
    CFG_LP_BTN      = 3'd2,
    CFG_LP_TIME     = 3'd3,
    CFG_LAYER_TIME  = 3'd4,
    CFG_DC_BTN      = 3'd5,
    CFG_DC_TIME     = 3'd6
  } cfg_idx_t;

  // Result action codes.
  typedef enum logic [2:0] {
    ACT_PRESS       = 3'd0,
    ACT_RELEASE     = 3'd1,
    ACT_DOUBLECLICK = 3'd2,
    ACT_LAYER_CMD1  = 3'd3,
    ACT_LAYER_CMD2  = 3'd4,
    ACT_LAYER_OPEN  = 3'd5,
    ACT_MODE_TOGGLE = 3'd6,
    ACT_LAYER_CLOSE = 3'd7
  } action_t;

  typedef struct packed {
    logic        enable;
    logic [7:0]  toggle_button;
    logic [7:0]  longpress_button;
    logic [15:0] longpress_time;
    logic [15:0] layer_time;
    logic [7:0]  doubleclick_button;
    logic [15:0] doubleclick_time;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  key_code;
    logic        pressed;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic        mode;
    logic        press_pending;
    logic        button_held;
    logic [31:0] press_stamp;
    logic [31:0] click_stamp;
    logic        layer_on;
    logic [31:0] layer_deadline;
  } st_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  key;
    logic        walk_mode;
    logic        layer_active;
  } res_t;

endpackage

>>> design/bgr_core.sv
// ----------------------------------------------------------------------------
// Button gesture router decision logic
// Combinational step: one item and the current state give up to two results
// and the next state.
// ----------------------------------------------------------------------------
module bgr_core
  import bgr_pkg::*;
(
  input  cfg_t       cfg,
  input  st_t        st,
  input  item_t      item,
  output st_t        st_nxt,
  output logic [1:0] num_res,
  output res_t       res0,
  output res_t       res1
);

  function automatic res_t mk_res(action_t act, logic [7:0] key, logic md, logic lyr);
    res_t r;
    r.action       = act;
    r.key          = key;
    r.walk_mode    = md;
    r.layer_active = lyr;
    return r;
  endfunction

  logic        lp_sel, dc_sel, lp_fire, lyr_close, dc_hit;
  logic [31:0] press_age, click_age, dl_diff;
  action_t     pass_act;

  always_comb begin
    lp_sel    = (item.key_code == cfg.longpress_button) &&
                (cfg.longpress_button >= MOUSE_ONE_CODE);
    dc_sel    = (item.key_code == cfg.doubleclick_button) &&
                (cfg.doubleclick_button >= MOUSE_ONE_CODE);
    press_age = item.time_ms - st.press_stamp;
    click_age = item.time_ms - st.click_stamp;
    dl_diff   = item.time_ms - st.layer_deadline;
    lp_fire   = st.press_pending && st.button_held &&
                (cfg.longpress_button >= MOUSE_ONE_CODE) &&
                (press_age >= {16'd0, cfg.longpress_time});
    // A layer opened by this very tick has its deadline ahead, so it cannot close.
    lyr_close = !lp_fire && st.layer_on && (dl_diff != 32'd0) && !dl_diff[31];
    dc_hit    = (st.click_stamp != 32'd0) && (click_age <= {16'd0, cfg.doubleclick_time});
    pass_act  = item.pressed ? ACT_PRESS : ACT_RELEASE;
  end

  always_comb begin
    st_nxt  = st;
    num_res = 2'd0;
    res0    = mk_res(ACT_PRESS, 8'd0, st.mode, st.layer_on);
    res1    = res0;
    if (item.kind) begin
      if (cfg.enable) begin
        if (lp_fire) begin
          st_nxt.press_pending  = 1'b0;
          st_nxt.layer_on       = 1'b1;
          st_nxt.layer_deadline = item.time_ms + {16'd0, cfg.layer_time};
          num_res               = 2'd1;
          res0                  = mk_res(ACT_LAYER_OPEN, 8'd0, st.mode, 1'b1);
        end else if (lyr_close) begin
          st_nxt.layer_on = 1'b0;
          num_res         = 2'd1;
          res0            = mk_res(ACT_LAYER_CLOSE, 8'd0, st.mode, 1'b0);
        end
      end
    end else if (!cfg.enable) begin
      num_res = 2'd1;
      res0    = mk_res(pass_act, item.key_code, st.mode, st.layer_on);
    end else if (item.pressed && (item.key_code == cfg.toggle_button)) begin
      st_nxt.mode = ~st.mode;
      num_res     = 2'd1;
      res0        = mk_res(ACT_MODE_TOGGLE, 8'd0, ~st.mode, st.layer_on);
    end else if (st.layer_on) begin
      num_res = 2'd1;
      if (item.pressed && (item.key_code == MOUSE_ONE_CODE)) begin
        st_nxt.layer_on = 1'b0;
        res0            = mk_res(ACT_LAYER_CMD1, 8'd0, st.mode, 1'b0);
      end else if (item.pressed && (item.key_code == MOUSE_TWO_CODE)) begin
        st_nxt.layer_on = 1'b0;
        res0            = mk_res(ACT_LAYER_CMD2, 8'd0, st.mode, 1'b0);
      end else begin
        res0 = mk_res(pass_act, item.key_code, st.mode, 1'b1);
      end
    end else if (lp_sel || dc_sel) begin
      if (item.pressed) begin
        st_nxt.button_held = 1'b1;
        if (lp_sel) begin
          st_nxt.press_pending = 1'b1;
          st_nxt.press_stamp   = item.time_ms;
        end else if (dc_hit) begin
          st_nxt.click_stamp = 32'd0;
          num_res            = 2'd2;
          res0               = mk_res(ACT_DOUBLECLICK, 8'd0, st.mode, st.layer_on);
          res1               = mk_res(ACT_PRESS, item.key_code, st.mode, st.layer_on);
        end else begin
          st_nxt.click_stamp = item.time_ms;
          num_res            = 2'd1;
          res0               = mk_res(ACT_PRESS, item.key_code, st.mode, st.layer_on);
        end
      end else begin
        st_nxt.button_held = 1'b0;
        if (st.press_pending) begin
          st_nxt.press_pending = 1'b0;
          num_res              = 2'd2;
          res0                 = mk_res(ACT_PRESS, item.key_code, st.mode, st.layer_on);
          res1                 = mk_res(ACT_RELEASE, item.key_code, st.mode, st.layer_on);
        end else begin
          num_res = 2'd1;
          res0    = mk_res(ACT_RELEASE, item.key_code, st.mode, st.layer_on);
        end
      end
    end else begin
      num_res = 2'd1;
      res0    = mk_res(pass_act, item.key_code, st.mode, st.layer_on);
    end
  end

endmodule

>>> design/bgr_outbuf.sv
// ----------------------------------------------------------------------------
// Button gesture router result buffer
// Two-entry result register that hands results out one per transfer.
// ----------------------------------------------------------------------------
`include "button_gesture_router_defines.svh"

module bgr_outbuf
  import bgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [1:0] num_res,
  input  res_t       res0,
  input  res_t       res1,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res,
  output logic       out_last
);

  res_t       ent0_r, ent1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  // The buffer takes a new batch once it is empty or its last entry leaves now.
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_res   = ent0_r;
  assign out_last  = (cnt_r == 2'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = num_res;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent0_r <= res0;
      ent1_r <= res1;
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
  end

  `BGR_ASSERT_NEXT(a_load_two, load && (num_res == 2'd2), (cnt_r == 2'd2) && (ent0_r == $past(res0)) && (ent1_r == $past(res1)), "two-result batch not stored")
  `BGR_ASSERT_NEXT(a_shift, pop && !load && (cnt_r == 2'd2), (cnt_r == 2'd1) && (ent0_r == $past(ent1_r)), "second result not moved up")
  `BGR_ASSERT_NEXT(a_empty_batch, load && (num_res == 2'd0), cnt_r == 2'd0, "empty batch left results")
  `BGR_ASSERT_NOW(a_no_overrun, load, (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop), "batch loaded over undelivered results")

endmodule

>>> design/button_gesture_router.sv
// ----------------------------------------------------------------------------
// Button gesture router
// Turns button events and time ticks into key actions: mode toggle, long
// press layer, layer commands, double click and pass-through.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Carries
//  in_*      input      in_valid / in_ready   one button event or time tick
//  out_*     output     out_valid / out_ready one action, out_last on the final one
//  cfg_*     input      cfg_write_en          register index and write data
//
//  An accepted item is held in the input register, then is decided in a
//  single pass that updates the gesture state and loads its zero to two
//  results into the result buffer. Items producing one result or none go at
//  one per cycle while out_ready is high; an item with two results occupies
//  the buffer for two output transfers, so the result port sets their rate.
//  Reset is synchronous and active low; there is no clearing pass.
//  A stalled out_ready backs up into the input register and then into in_ready.
// ----------------------------------------------------------------------------
module button_gesture_router
  import bgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_key_code,
  input  logic        in_pressed,
  input  logic [31:0] in_time_ms,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [7:0]  out_key,
  output logic        out_walk_mode,
  output logic        out_layer_active,
  output logic        out_last,
  // Configuration port
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  st_t        st_r, st_nxt;
  item_t      item_r;
  logic       item_vld_r;
  logic       can_load, fire;
  logic [1:0] num_res;
  res_t       res0, res1, out_res;
  logic       en_flip;

  // The decision stage fires whenever a held item exists and the result
  // buffer has room; the input register refills in the same cycle.
  assign fire     = item_vld_r && can_load;
  assign in_ready = !item_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  // Payload captured on each input transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind     <= in_kind;
      item_r.key_code <= in_key_code;
      item_r.pressed  <= in_pressed;
      item_r.time_ms  <= in_time_ms;
    end
  end

  // Configuration registers. A write that changes enable also wipes the
  // gesture state below (held button, press stamp and layer deadline survive).
  assign en_flip = cfg_write_en && (cfg_idx_t'(cfg_index) == CFG_ENABLE) &&
                   (cfg_data[0] != cfg_r.enable);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable             <= 1'b1;
      cfg_r.toggle_button      <= 8'd201;
      cfg_r.longpress_button   <= 8'd0;
      cfg_r.longpress_time     <= 16'd400;
      cfg_r.layer_time         <= 16'd3000;
      cfg_r.doubleclick_button <= 8'd0;
      cfg_r.doubleclick_time   <= 16'd350;
    end else if (cfg_write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:     cfg_r.enable             <= cfg_data[0];
        CFG_TOGGLE_BTN: cfg_r.toggle_button      <= cfg_data[7:0];
        CFG_LP_BTN:     cfg_r.longpress_button   <= cfg_data[7:0];
        CFG_LP_TIME:    cfg_r.longpress_time     <= cfg_data;
        CFG_LAYER_TIME: cfg_r.layer_time         <= cfg_data;
        CFG_DC_BTN:     cfg_r.doubleclick_button <= cfg_data[7:0];
        CFG_DC_TIME:    cfg_r.doubleclick_time   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gesture state. Configuration writes must arrive only while the block is idle;
  // the block does not enforce this, and an enable wipe overrides a decision.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (en_flip) begin
      st_r.press_pending <= 1'b0;
      st_r.click_stamp   <= 32'd0;
      st_r.layer_on      <= 1'b0;
      st_r.mode          <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  bgr_core u_core (
    .cfg     (cfg_r),
    .st      (st_r),
    .item    (item_r),
    .st_nxt  (st_nxt),
    .num_res (num_res),
    .res0    (res0),
    .res1    (res1)
  );

  bgr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .num_res   (num_res),
    .res0      (res0),
    .res1      (res1),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign out_action       = out_res.action;
  assign out_key          = out_res.key;
  assign out_walk_mode    = out_res.walk_mode;
  assign out_layer_active = out_res.layer_active;

endmodule
